>>> sv/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_SIDE_DEF  = 4096;
   localparam int FRAC_BITS_DEF = 28;

   // Fraction bits of the window coordinates held in the registers.
   localparam int COORD_FRAC = 28;

   // Dividend width of the shared divider. The widest dividend is a 32-bit
   // span magnitude times a 24-bit pixel position.
   localparam int DVD_W = 56;
   localparam int DVS_W = 16;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   // Register reset values.
   localparam logic [12:0]        RST_IMAGE_WIDTH    = 13'd640;
   localparam logic [12:0]        RST_IMAGE_HEIGHT   = 13'd480;
   localparam logic [15:0]        RST_MAX_ITERATIONS = 16'd255;
   localparam logic signed [31:0] RST_TOP_EDGE       = -32'sd268435456;
   localparam logic signed [31:0] RST_LEFT_EDGE      = -32'sd536870912;
   localparam logic signed [31:0] RST_SPAN_WIDTH     = 32'sd805306368;
   localparam logic signed [31:0] RST_SPAN_HEIGHT    = 32'sd536870912;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_MAX_ITERATIONS,
      REG_TOP_EDGE,
      REG_LEFT_EDGE,
      REG_SPAN_WIDTH,
      REG_SPAN_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [23:0] pixel_index;
      logic        last_in_batch;
   } req_payload_type;

   typedef struct packed {
      logic [23:0] pixel_offset;
      logic [7:0]  shade;
      logic        batch_end;
   } rsp_payload_type;

   // Result of the shared multiplier: the exact magnitude product (low 64 bits)
   // and the signed, rescaled and saturated fixed-point product.
   typedef struct packed {
      logic               done;
      logic [63:0]        raw;
      logic signed [63:0] scaled;
   } mul_out_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_out_type;

endpackage

>>> sv/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time shader, one pixel per transaction. The pixel index is
// split into row and column by the image width, mapped onto a point c of the
// configured window, and z = z*z + c is iterated from z = c until |z|^2 exceeds
// 4 or the count reaches max_iterations; the response carries the index, the
// shade 255*count/max_iterations and the batch flag. One pixel is worked on at
// a time and req_ready is high only while the engine is idle. Most of the work
// on a pixel goes into four passes of the shared 56-step restoring divider
// (row/column split, both coordinate mappings and the shade) and, for each
// iteration, into three 64x64 fixed-point products, each built from four
// 32x32 partial products on the single shared multiplier. A finished response
// waits in an output register, so the next request transaction is taken while
// the response transaction is still pending. The configuration registers are
// written through the csr_ port, which is always ready; write them only while no
// pixel is in flight. Image width and height are clamped to 1..MAX_SIDE before
// use, and a zero iteration limit gives shade 0.
module mandelbrot_escape_time_pixel #(
   parameter int MAX_SIDE  = mbe_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mbe_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mbe_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata
);

   localparam logic [16:0] SIDE_LIM = 17'(MAX_SIDE);
   localparam int SHL = (FRAC_BITS >= mbe_pkg::COORD_FRAC) ?
                        FRAC_BITS - mbe_pkg::COORD_FRAC : 0;
   localparam int SHR = (FRAC_BITS < mbe_pkg::COORD_FRAC) ?
                        mbe_pkg::COORD_FRAC - FRAC_BITS : 0;
   localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SPLIT,
      S_MAPX_MUL,
      S_MAPX_DIV,
      S_MAPY_MUL,
      S_MAPY_DIV,
      S_SQ_X,
      S_SQ_Y,
      S_CHECK,
      S_CROSS,
      S_SHADE,
      S_DONE
   } state_type;

   // Saturating signed 64-bit addition.
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
      end
      return s;
   endfunction

   // Converts a window coordinate to the internal fraction width. Widening
   // saturates; narrowing truncates toward zero.
   function automatic logic signed [63:0] to_internal(input logic signed [63:0] v);
      logic signed [63:0] lim;
      logic [63:0]        mag;
      logic [63:0]        t;
      lim = mbe_pkg::S64_MAX >>> SHL;
      mag = v[63] ? 64'(-v) : 64'(v);
      t   = mag >> SHR;
      if (FRAC_BITS >= mbe_pkg::COORD_FRAC) begin
         if (v > lim) return mbe_pkg::S64_MAX;
         if (v < -lim) return mbe_pkg::S64_MIN;
         return v <<< SHL;
      end
      return v[63] ? -$signed(t) : $signed(t);
   endfunction

   // Configuration registers.
   logic [12:0]        image_width_ff;
   logic [12:0]        image_height_ff;
   logic [15:0]        max_iterations_ff;
   logic signed [31:0] top_edge_ff;
   logic signed [31:0] left_edge_ff;
   logic signed [31:0] span_width_ff;
   logic signed [31:0] span_height_ff;

   // Sequencer state and working registers.
   state_type          state_ff;
   logic [23:0]        idx_ff;
   logic               last_ff;
   logic [23:0]        row_ff;
   logic signed [63:0] cx_ff;
   logic signed [63:0] cy_ff;
   logic signed [63:0] zx_ff;
   logic signed [63:0] zy_ff;
   logic signed [63:0] xx_ff;
   logic signed [63:0] yy_ff;
   logic [15:0]        count_ff;
   logic [7:0]         shade_ff;
   logic               rsp_valid_ff;
   mbe_pkg::rsp_payload_type rsp_data_ff;

   // Commands to the shared units.
   logic                        mul_start_ff;
   logic signed [63:0]          mul_a_ff;
   logic signed [63:0]          mul_b_ff;
   logic                        div_start_ff;
   logic [mbe_pkg::DVD_W-1:0]   div_dvd_ff;
   logic [mbe_pkg::DVS_W-1:0]   div_dvs_ff;

   mbe_pkg::mul_out_type mul_out;
   mbe_pkg::div_out_type div_out;

   logic [15:0]               w_side;
   logic [15:0]               h_side;
   logic [63:0]               map_mag;
   logic signed [63:0]        map_v;
   logic signed [63:0]        map_c;
   logic signed [63:0]        magsq;
   logic                      keep_going;
   logic signed [63:0]        nx;
   logic signed [63:0]        ny;
   logic [23:0]               shade_num;

   mbe_mulq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mulq (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .mul_out (mul_out)
   );

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dvs_ff),
      .div_out  (div_out)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= mbe_pkg::RST_IMAGE_WIDTH;
         image_height_ff   <= mbe_pkg::RST_IMAGE_HEIGHT;
         max_iterations_ff <= mbe_pkg::RST_MAX_ITERATIONS;
         top_edge_ff       <= mbe_pkg::RST_TOP_EDGE;
         left_edge_ff      <= mbe_pkg::RST_LEFT_EDGE;
         span_width_ff     <= mbe_pkg::RST_SPAN_WIDTH;
         span_height_ff    <= mbe_pkg::RST_SPAN_HEIGHT;
      end else if (csr_valid) begin
         unique case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::REG_IMAGE_WIDTH:    image_width_ff    <= csr_wdata[12:0];
            mbe_pkg::REG_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata[12:0];
            mbe_pkg::REG_MAX_ITERATIONS: max_iterations_ff <= csr_wdata[15:0];
            mbe_pkg::REG_TOP_EDGE:       top_edge_ff       <= $signed(csr_wdata);
            mbe_pkg::REG_LEFT_EDGE:      left_edge_ff      <= $signed(csr_wdata);
            mbe_pkg::REG_SPAN_WIDTH:     span_width_ff     <= $signed(csr_wdata);
            mbe_pkg::REG_SPAN_HEIGHT:    span_height_ff    <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Width and height are clamped to 1..MAX_SIDE before they serve as divisors.
   always_comb begin
      if (image_width_ff == 13'd0) begin
         w_side = 16'd1;
      end else if ({4'b0, image_width_ff} > SIDE_LIM) begin
         w_side = SIDE_LIM[15:0];
      end else begin
         w_side = {3'b0, image_width_ff};
      end
      if (image_height_ff == 13'd0) begin
         h_side = 16'd1;
      end else if ({4'b0, image_height_ff} > SIDE_LIM) begin
         h_side = SIDE_LIM[15:0];
      end else begin
         h_side = {3'b0, image_height_ff};
      end
   end

   // Coordinate mapping: the divider returns |span * pos| / side; the sign of
   // the span is put back (truncation toward zero) and the edge is added.
   always_comb begin
      map_mag = {{(64 - mbe_pkg::DVD_W){1'b0}}, div_out.quotient};
      if (state_ff == S_MAPY_DIV) begin
         map_v = span_height_ff[31] ? -$signed(map_mag) : $signed(map_mag);
         map_v = map_v + 64'(top_edge_ff);
      end else begin
         map_v = span_width_ff[31] ? -$signed(map_mag) : $signed(map_mag);
         map_v = map_v + 64'(left_edge_ff);
      end
      map_c = to_internal(map_v);
   end

   // Escape test and the next z. Both squares are non-negative, so their
   // difference cannot overflow.
   always_comb begin
      magsq      = sat_add(xx_ff, yy_ff);
      keep_going = (magsq <= FOUR) && (count_ff != max_iterations_ff);
      nx         = sat_add(xx_ff - yy_ff, cx_ff);
      ny         = sat_add(sat_add(mul_out.scaled, mul_out.scaled), cy_ff);
      shade_num  = {count_ff, 8'b0} - {8'b0, count_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         // The completion step sets valid itself when it reloads the register.
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  idx_ff       <= req_data.pixel_index;
                  last_ff      <= req_data.last_in_batch;
                  div_dvd_ff   <= mbe_pkg::DVD_W'(req_data.pixel_index);
                  div_dvs_ff   <= w_side;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_SPLIT;
               end
            end
            S_SPLIT: begin
               if (div_out.done) begin
                  row_ff       <= div_out.quotient[23:0];
                  mul_a_ff     <= 64'(span_width_ff);
                  mul_b_ff     <= $signed({48'b0, div_out.remainder});
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MAPX_MUL;
               end
            end
            S_MAPX_MUL: begin
               if (mul_out.done) begin
                  div_dvd_ff   <= mul_out.raw[mbe_pkg::DVD_W-1:0];
                  div_dvs_ff   <= w_side;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_MAPX_DIV;
               end
            end
            S_MAPX_DIV: begin
               if (div_out.done) begin
                  cx_ff        <= map_c;
                  mul_a_ff     <= 64'(span_height_ff);
                  mul_b_ff     <= $signed({40'b0, row_ff});
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MAPY_MUL;
               end
            end
            S_MAPY_MUL: begin
               if (mul_out.done) begin
                  div_dvd_ff   <= mul_out.raw[mbe_pkg::DVD_W-1:0];
                  div_dvs_ff   <= h_side;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_MAPY_DIV;
               end
            end
            S_MAPY_DIV: begin
               if (div_out.done) begin
                  cy_ff        <= map_c;
                  zy_ff        <= map_c;
                  zx_ff        <= cx_ff;
                  count_ff     <= 16'd0;
                  mul_a_ff     <= cx_ff;
                  mul_b_ff     <= cx_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQ_X;
               end
            end
            S_SQ_X: begin
               if (mul_out.done) begin
                  xx_ff        <= mul_out.scaled;
                  mul_a_ff     <= zy_ff;
                  mul_b_ff     <= zy_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQ_Y;
               end
            end
            S_SQ_Y: begin
               if (mul_out.done) begin
                  yy_ff    <= mul_out.scaled;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (keep_going) begin
                  mul_a_ff     <= zx_ff;
                  mul_b_ff     <= zy_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_CROSS;
               end else if (max_iterations_ff == 16'd0) begin
                  shade_ff <= 8'd0;
                  state_ff <= S_DONE;
               end else begin
                  div_dvd_ff   <= mbe_pkg::DVD_W'(shade_num);
                  div_dvs_ff   <= max_iterations_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_SHADE;
               end
            end
            S_CROSS: begin
               if (mul_out.done) begin
                  zx_ff        <= nx;
                  zy_ff        <= ny;
                  count_ff     <= count_ff + 16'd1;
                  mul_a_ff     <= nx;
                  mul_b_ff     <= nx;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQ_X;
               end
            end
            S_SHADE: begin
               if (div_out.done) begin
                  shade_ff <= div_out.quotient[7:0];
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.pixel_offset <= idx_ff;
                  rsp_data_ff.shade        <= shade_ff;
                  rsp_data_ff.batch_end    <= last_ff;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The multiplier and the divider are never running at the same time.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_out.done && div_out.done))
      else $error("multiplier and divider finished in the same cycle");

   // A multiplier result only arrives while the sequencer waits for one.
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_out.done |-> (state_ff == S_MAPX_MUL || state_ff == S_MAPY_MUL ||
                        state_ff == S_SQ_X || state_ff == S_SQ_Y ||
                        state_ff == S_CROSS))
      else $error("multiplier result arrived outside a multiply step");

   // The iteration count never passes the limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (count_ff <= max_iterations_ff))
      else $error("iteration count beyond max_iterations");

   // A new response transaction is only raised by the completion step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the completion step");

endmodule

>>> sv/mbe_mulq.sv
`timescale 1ns / 1ps

module mbe_mulq #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  op_a,
   input  logic signed [63:0]  op_b,
   output mbe_pkg::mul_out_type mul_out
);

   localparam logic [2:0] LAST_CYC = 3'd5;

   logic [63:0]  ua_ff;
   logic [63:0]  ub_ff;
   logic         neg_ff;
   logic [127:0] acc_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sel_ff;
   logic [2:0]   cyc_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  raw_ff;
   logic signed [63:0] scaled_ff;

   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [63:0]  pp_in;
   logic [127:0] pp_shifted;
   logic [63:0]  q_word;
   logic         ovf;
   logic signed [63:0] scaled_in;

   // Four 32x32 partial products, one per cycle: low*low, low*high,
   // high*low, high*high.
   always_comb begin
      a_half = cyc_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_half = cyc_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp_in  = a_half * b_half;
   end

   always_comb begin
      case (sel_ff) inside
         2'd0:       pp_shifted = {64'b0, pp_ff};
         2'd1, 2'd2: pp_shifted = {32'b0, pp_ff, 32'b0};
         default:    pp_shifted = {pp_ff, 64'b0};
      endcase
   end

   // The product is shifted down by the fraction width, truncating the
   // magnitude, and saturated to the signed 64-bit range.
   always_comb begin
      q_word = acc_ff[FRAC_BITS +: 64];
      ovf    = (acc_ff >> (64 + FRAC_BITS)) != 128'd0;
      if (ovf) begin
         scaled_in = neg_ff ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
      end else if (!neg_ff) begin
         scaled_in = q_word[63] ? mbe_pkg::S64_MAX : $signed(q_word);
      end else begin
         scaled_in = q_word[63] ? mbe_pkg::S64_MIN : -$signed(q_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cyc_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            ua_ff   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
            ub_ff   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
            neg_ff  <= op_a[63] ^ op_b[63];
            acc_ff  <= 128'd0;
            cyc_ff  <= 3'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!cyc_ff[2]) begin
               pp_ff  <= pp_in;
               sel_ff <= cyc_ff[1:0];
            end
            if (cyc_ff != 3'd0 && cyc_ff != LAST_CYC) begin
               acc_ff <= acc_ff + pp_shifted;
            end
            if (cyc_ff == LAST_CYC) begin
               raw_ff    <= acc_ff[63:0];
               scaled_ff <= scaled_in;
               done_ff   <= 1'b1;
               busy_ff   <= 1'b0;
            end
            cyc_ff <= cyc_ff + 3'd1;
         end
      end
   end

   assign mul_out.done   = done_ff;
   assign mul_out.raw    = raw_ff;
   assign mul_out.scaled = scaled_ff;

endmodule

>>> sv/mbe_div.sv
`timescale 1ns / 1ps

module mbe_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mbe_pkg::DVD_W-1:0]         dividend,
   input  logic [mbe_pkg::DVS_W-1:0]         divisor,
   output mbe_pkg::div_out_type              div_out
);

   localparam int CNT_W = $clog2(mbe_pkg::DVD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(mbe_pkg::DVD_W - 1);

   logic [mbe_pkg::DVD_W-1:0] quo_ff;
   logic [mbe_pkg::DVS_W-1:0] rem_ff;
   logic [mbe_pkg::DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;

   logic [mbe_pkg::DVS_W:0]   shifted;
   logic [mbe_pkg::DVS_W+1:0] diff;
   logic                      borrow;

   // One restoring step: bring down the next dividend bit and subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[mbe_pkg::DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b0, dvs_ff};
      borrow  = diff[mbe_pkg::DVS_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= borrow ? shifted[mbe_pkg::DVS_W-1:0] : diff[mbe_pkg::DVS_W-1:0];
            quo_ff <= {quo_ff[mbe_pkg::DVD_W-2:0], ~borrow};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_out.done      = done_ff;
   assign div_out.quotient  = quo_ff;
   assign div_out.remainder = rem_ff;

endmodule

>>> test/mandelbrot_escape_time_pixel_checker.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  mbe_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  mbe_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   output int                       mismatches,
   output int                       outstanding,
   output int                       responses
);

   localparam int                 FRAC         = mbe_pkg::FRAC_BITS_DEF;
   localparam int                 SIDE_LIMIT   = mbe_pkg::MAX_SIDE_DEF;
   localparam logic signed [63:0] ESCAPE_LIMIT = 64'sd4 <<< FRAC;
   localparam int unsigned        SHADE_FULL   = 255;

   // Shadow copy of the register file, kept from the observed write transactions.
   logic [12:0]        width_q;
   logic [12:0]        height_q;
   logic [15:0]        iter_limit_q;
   logic signed [31:0] top_q;
   logic signed [31:0] left_q;
   logic signed [31:0] span_w_q;
   logic signed [31:0] span_h_q;

   mbe_pkg::rsp_payload_type expected_pixels[$];
   int                       mismatch_total;
   int                       response_total;

   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
      return s[63:0];
   endfunction

   // Exact product of the magnitudes, shifted down by the fraction bits and
   // truncated, then signed and saturated.
   function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  q;
      logic [127:0] prod;
      logic         neg;
      ua   = a[63] ? 64'd0 - a : a;
      ub   = b[63] ? 64'd0 - b : b;
      neg  = a[63] ^ b[63];
      prod = {64'd0, ua} * {64'd0, ub};
      if (prod[127:FRAC+64] != '0) return neg ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
      q = prod[FRAC+63:FRAC];
      if (!neg) return q[63] ? mbe_pkg::S64_MAX : q;
      return q[63] ? mbe_pkg::S64_MIN : 64'd0 - q;
   endfunction

   function automatic longint side_divisor(input logic [12:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIMIT) return SIDE_LIMIT;
      return v;
   endfunction

   // The engine works at the register precision, so no rescale follows.
   function automatic logic signed [63:0] axis_coord(input logic signed [31:0] origin,
                                                     input logic signed [31:0] extent,
                                                     input longint pos,
                                                     input longint div);
      return longint'(extent) * pos / div + longint'(origin);
   endfunction

   function automatic mbe_pkg::rsp_payload_type shade_of_pixel(
         input mbe_pkg::req_payload_type px);
      longint                   cols;
      longint                   rows;
      longint                   idx;
      logic signed [63:0]       cx;
      logic signed [63:0]       cy;
      logic signed [63:0]       zx;
      logic signed [63:0]       zy;
      logic signed [63:0]       re_sq;
      logic signed [63:0]       cross_term;
      logic signed [63:0]       mag_sq;
      int unsigned              count;
      mbe_pkg::rsp_payload_type res;
      cols   = side_divisor(width_q);
      rows   = side_divisor(height_q);
      idx    = px.pixel_index;
      cx     = axis_coord(left_q, span_w_q, idx % cols, cols);
      cy     = axis_coord(top_q, span_h_q, idx / cols, rows);
      zx     = cx;
      zy     = cy;
      mag_sq = sat_sum(fixed_mul(zx, zx), fixed_mul(zy, zy));
      count  = 0;
      while (mag_sq <= ESCAPE_LIMIT && count != iter_limit_q) begin
         re_sq      = sat_sum(fixed_mul(zx, zx), -fixed_mul(zy, zy));
         cross_term = fixed_mul(zx, zy);
         zy         = sat_sum(sat_sum(cross_term, cross_term), cy);
         zx         = sat_sum(re_sq, cx);
         mag_sq     = sat_sum(fixed_mul(zx, zx), fixed_mul(zy, zy));
         count++;
      end
      res.pixel_offset = px.pixel_index;
      res.shade        = (iter_limit_q == 0) ? 8'd0 : 8'((SHADE_FULL * count) / iter_limit_q);
      res.batch_end    = px.last_in_batch;
      return res;
   endfunction

   always @(posedge clock) begin : track
      mbe_pkg::rsp_payload_type want;
      if (reset) begin
         width_q      = mbe_pkg::RST_IMAGE_WIDTH;
         height_q     = mbe_pkg::RST_IMAGE_HEIGHT;
         iter_limit_q = mbe_pkg::RST_MAX_ITERATIONS;
         top_q        = mbe_pkg::RST_TOP_EDGE;
         left_q       = mbe_pkg::RST_LEFT_EDGE;
         span_w_q     = mbe_pkg::RST_SPAN_WIDTH;
         span_h_q     = mbe_pkg::RST_SPAN_HEIGHT;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mbe_pkg::REG_IMAGE_WIDTH:    width_q      = csr_wdata[12:0];
               mbe_pkg::REG_IMAGE_HEIGHT:   height_q     = csr_wdata[12:0];
               mbe_pkg::REG_MAX_ITERATIONS: iter_limit_q = csr_wdata[15:0];
               mbe_pkg::REG_TOP_EDGE:       top_q        = csr_wdata;
               mbe_pkg::REG_LEFT_EDGE:      left_q       = csr_wdata;
               mbe_pkg::REG_SPAN_WIDTH:     span_w_q     = csr_wdata;
               mbe_pkg::REG_SPAN_HEIGHT:    span_h_q     = csr_wdata;
               default: ;
            endcase
         end
         // Responses are matched before this edge's request is queued, so a
         // response can never be paired with the request taken alongside it.
         if (rsp_valid && rsp_ready) begin
            response_total++;
            if (expected_pixels.size() == 0) begin
               $error("pixel %0d answered with no request outstanding", rsp_data.pixel_offset);
               mismatch_total++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_offset !== want.pixel_offset) begin
                  $error("pixel_offset: expected %0d, got %0d",
                         want.pixel_offset, rsp_data.pixel_offset);
                  mismatch_total++;
               end
               if (rsp_data.shade !== want.shade) begin
                  $error("shade: expected %0d, got %0d (pixel %0d)",
                         want.shade, rsp_data.shade, want.pixel_offset);
                  mismatch_total++;
               end
               if (rsp_data.batch_end !== want.batch_end) begin
                  $error("batch_end: expected %0b, got %0b (pixel %0d)",
                         want.batch_end, rsp_data.batch_end, want.pixel_offset);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) expected_pixels.push_back(shade_of_pixel(req_data));
      end
      mismatches  <= mismatch_total;
      outstanding <= expected_pixels.size();
      responses   <= response_total;
   end

endmodule

>>> test/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the escape-time shader. The checker instance sits on
// all three channels and does the prediction and comparison; this module only
// drives transactions, waits for the engine to go idle between register
// settings, and reports the outcome.
module mandelbrot_escape_time_pixel_tb;

   localparam int         PIXEL_GOAL      = 1500;
   // From this many pixels on, neither side inserts idle cycles.
   localparam int         QUIET_FROM      = 1300;
   localparam int         DRAIN_CYCLES    = 400;
   localparam int         SIDE_LIMIT      = mbe_pkg::MAX_SIDE_DEF;
   // Register index with no register behind it; writes there must be ignored.
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   mbe_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   mbe_pkg::rsp_payload_type rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [2:0]               csr_index;
   logic [31:0]              csr_wdata;

   int          mismatches;
   int          outstanding;
   int          responses;
   int          sent;
   int          phases;
   int unsigned cols_used;
   int unsigned rows_used;
   logic        quiet_tail;

   always #5 clock = ~clock;

   mandelbrot_escape_time_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mandelbrot_escape_time_pixel_checker shade_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .responses   (responses)
   );

   // The image sides the engine actually divides by, used to aim pixel
   // indexes inside the picture.
   function automatic int unsigned clamped_side(input logic [12:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIMIT) return SIDE_LIMIT;
      return v;
   endfunction

   // Leaves csr_valid high on return so that back-to-back writes never lower
   // and raise it within one time step; the caller drops it after the last one.
   task automatic put_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes the whole register file. Only called while no pixel is in flight.
   task automatic load_settings(input logic [31:0] width_word, input logic [31:0] height_word,
                                input logic [31:0] iter_word, input logic [31:0] top_word,
                                input logic [31:0] left_word, input logic [31:0] span_w_word,
                                input logic [31:0] span_h_word);
      put_reg(mbe_pkg::REG_IMAGE_WIDTH, width_word);
      put_reg(mbe_pkg::REG_IMAGE_HEIGHT, height_word);
      put_reg(mbe_pkg::REG_MAX_ITERATIONS, iter_word);
      put_reg(mbe_pkg::REG_TOP_EDGE, top_word);
      put_reg(mbe_pkg::REG_LEFT_EDGE, left_word);
      put_reg(mbe_pkg::REG_SPAN_WIDTH, span_w_word);
      put_reg(mbe_pkg::REG_SPAN_HEIGHT, span_h_word);
      csr_valid <= 1'b0;
      cols_used = clamped_side(width_word[12:0]);
      rows_used = clamped_side(height_word[12:0]);
      phases++;
   endtask

   // One request transaction, optionally preceded by an idle burst. Valid is
   // left high after acceptance; the next call either keeps it high with new
   // data or drops it for a gap.
   task automatic send_pixel(input logic [23:0] idx, input logic last);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= mbe_pkg::req_payload_type'({idx, last});
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Waits until every pixel sent so far has been answered; the engine holds
   // one pixel at a time, so it is idle from then on.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (responses < sent) @(posedge clock);
   endtask

   // Response side back-pressure: random stalls between runs of readiness,
   // switched off for the tail of the run.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [31:0] width_word;
      logic [31:0] height_word;
      logic [31:0] iter_word;
      logic [31:0] top_word;
      logic [31:0] left_word;
      logic [31:0] span_w_word;
      logic [31:0] span_h_word;
      int          batch_len;
      logic [23:0] pick;
      logic        last;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      quiet_tail <= 1'b0;
      sent       = 0;
      phases     = 1;
      cols_used  = clamped_side(mbe_pkg::RST_IMAGE_WIDTH);
      rows_used  = clamped_side(mbe_pkg::RST_IMAGE_HEIGHT);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset window, 640x480 over [-2,1] x [-1,1] with a limit of 255. The
      // first corner escapes at once, the center pixel (-0.5, 0) lies in the
      // main cardioid and runs to the limit, (0.34375, 0) escapes after a
      // handful of steps, and the last index lies far below the picture.
      send_pixel(24'd0, 1'b0);
      send_pixel(24'd153920, 1'b0);
      send_pixel(24'd154100, 1'b0);
      send_pixel(24'd307199, 1'b0);
      send_pixel(24'hFF_FFFF, 1'b1);
      wait_idle();

      // Zero image sides clamp to one, so every index is a row of its own; a
      // zero iteration limit forces shade 0. The window takes the extreme
      // register values and the unused index is written as well.
      put_reg(CSR_SPARE_INDEX, $urandom());
      load_settings(32'hFFFF_E000, 32'hFFFF_E000, 32'hFFFF_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_pixel(24'd0, 1'b1);
      send_pixel(24'hFF_FFFF, 1'b0);
      send_pixel(24'h55_AAAA, 1'b1);
      wait_idle();

      // Oversized sides clamp to 4096 and the limit is the largest one. The
      // window starts at real part 4.0 and grows to the right, so every pixel
      // escapes before the first iteration and the long limit costs nothing.
      load_settings(32'h0000_1FFF, 32'hA5A5_1FFF, 32'h0000_FFFF, 32'h8000_0000,
                    32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pixel(24'd4095, 1'b0);
      send_pixel(24'd4096, 1'b0);
      send_pixel(24'hFF_FFFF, 1'b1);
      send_pixel(24'd0, 1'b0);
      wait_idle();

      // A 4x4 picture over [-2,0.5] x [-1.25,1.25] with a limit above 255, so
      // the shade scaling divides by something other than its numerator.
      // Pixel 10 sits on the cusp between cardioid and bulb at -0.75.
      load_settings(32'd4, 32'd4, 32'd300, 32'hEC00_0000, 32'hE000_0000,
                    32'h2800_0000, 32'h2800_0000);
      send_pixel(24'd0, 1'b0);
      send_pixel(24'd5, 1'b0);
      send_pixel(24'd10, 1'b0);
      send_pixel(24'd15, 1'b1);
      wait_idle();

      // Random settings, each followed by a batch of pixels. Most windows
      // frame the set so iteration counts spread out; some are fully random.
      // Limits stay small except in short batches, which keeps the run short.
      while (sent < PIXEL_GOAL) begin
         if (sent >= QUIET_FROM) quiet_tail <= 1'b1;
         width_word  = $urandom();
         height_word = $urandom();
         iter_word   = $urandom();
         width_word[12:0]  = ($urandom_range(0, 7) == 0) ? 13'($urandom())
                                                         : 13'($urandom_range(1, 64));
         height_word[12:0] = ($urandom_range(0, 7) == 0) ? 13'($urandom())
                                                         : 13'($urandom_range(1, 64));
         case ($urandom_range(0, 7))
            0:       iter_word[15:0] = 16'($urandom_range(64, 300));
            1:       iter_word[15:0] = 16'($urandom_range(0, 1));
            default: iter_word[15:0] = 16'($urandom_range(2, 24));
         endcase
         batch_len = (iter_word[15:0] > 24) ? $urandom_range(2, 6) : $urandom_range(20, 70);
         if ($urandom_range(0, 5) == 0) begin
            top_word    = $urandom();
            left_word   = $urandom();
            span_w_word = $urandom();
            span_h_word = $urandom();
         end else begin
            // Real part from -2.5 to -0.5, imaginary part from -1.5 to -0.5,
            // spans from 1/16 to 3, occasionally mirrored.
            left_word   = -671088640 + int'($urandom_range(0, 536870912));
            top_word    = -402653184 + int'($urandom_range(0, 268435456));
            span_w_word = $urandom_range(16777216, 805306368);
            span_h_word = $urandom_range(16777216, 805306368);
            if ($urandom_range(0, 3) == 0) span_w_word = -span_w_word;
            if ($urandom_range(0, 3) == 0) span_h_word = -span_h_word;
         end
         load_settings(width_word, height_word, iter_word, top_word, left_word,
                       span_w_word, span_h_word);
         for (int i = 0; i < batch_len; i++) begin
            // Mostly pixels inside the picture; now and then any index at all.
            pick = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                               : 24'($urandom_range(0, cols_used * rows_used - 1));
            last = ($urandom_range(0, 5) == 0) || (i == batch_len - 1);
            send_pixel(pick, last);
         end
         wait_idle();
      end

      // Give a stray extra response time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outstanding != 0) $error("%0d pixels were never answered", outstanding);
      $display("Sent %0d pixel transactions over %0d register settings; %0d responses checked.",
               sent, phases, responses);
      $display("Settings included clamped image sides, iteration limits 0 to 65535 and %s",
               "full-scale windows.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: 400 ms is several times the slowest legal run, where every pixel
   // iterates to its limit and every response waits out the longest stall.
   initial begin
      #400_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
